>>> design/ps2mt_pkg.sv
// Package: shared constants, status codes and the result record of the PS/2 packet tracker.
`timescale 1ns / 1ps
package ps2mt_pkg;

  // Bytes per mouse packet: 3 for a plain mouse, 4 with a wheel byte.
  localparam int PACKET_BYTES = 4;
  // Bytes of a packet that are kept (header, X low, Y low).
  localparam int STORE_DEPTH  = 3;
  localparam int POS_W        = 32;
  localparam int COUNT_W      = 2;

  // Header bit positions of byte 0.
  localparam int HDR_LEFT   = 0;
  localparam int HDR_RIGHT  = 1;
  localparam int HDR_MIDDLE = 2;
  localparam int HDR_SYNC   = 3;
  localparam int HDR_XSIGN  = 4;
  localparam int HDR_YSIGN  = 5;

  // Low nibble a byte must show to be taken as a new header while resyncing:
  // sync, right and left set, middle clear.
  localparam logic [3:0] RESYNC_NIBBLE = 4'b1011;

  typedef enum logic [2:0] {
    STATUS_ABSORBED = 3'd0,
    STATUS_APPLIED  = 3'd1,
    STATUS_CORRUPT  = 3'd2,
    STATUS_REJECTED = 3'd3,
    STATUS_RESYNCED = 3'd4
  } status_e;

  typedef struct packed {
    status_e                  status;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic [2:0]               btn;    // bit0 left, bit1 right, bit2 middle
  } result_t;

endpackage

>>> design/ps2_mouse_packet_tracker.sv
// Top level of the PS/2 mouse packet tracker: byte framing plus result buffer.
`timescale 1ns / 1ps
// Accepts one raw PS/2 mouse byte per transfer and returns one result per
// byte, in order. Bytes are framed into packets of ps2mt_pkg::PACKET_BYTES;
// a complete packet with its sync bit set adds its 9-bit X delta to pos_x_o,
// subtracts its 9-bit Y delta from pos_y_o (screen coordinates, 32-bit
// wrapping) and latches the three buttons. A complete packet with the sync
// bit clear reports corrupt and enters resync, where only a byte with sync,
// left and right set and middle clear starts a new packet. Rate: one byte
// per clock while in_stall_o is low; each result is registered in the result
// buffer. The framing and position update finish in the accept cycle, and a
// two-entry result buffer lets input transfers continue after the output
// stalls; in_stall_o rises only when both entries hold results.
module ps2_mouse_packet_tracker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [7:0]                         data_byte_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [2:0]                         status_o,
  output logic signed [ps2mt_pkg::POS_W-1:0] pos_x_o,
  output logic signed [ps2mt_pkg::POS_W-1:0] pos_y_o,
  output logic                               btn_left_o,
  output logic                               btn_right_o,
  output logic                               btn_middle_o
);

  logic               accept;
  logic               buf_full;
  ps2mt_pkg::result_t step_res;
  ps2mt_pkg::result_t out_res;

  // Take a byte whenever the result buffer has room for its result.
  assign accept     = in_valid_i & ~buf_full;
  assign in_stall_o = buf_full;

  ps2mt_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .result_o    (step_res)
  );

  ps2mt_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (step_res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_res)
  );

  assign status_o     = out_res.status;
  assign pos_x_o      = out_res.pos_x;
  assign pos_y_o      = out_res.pos_y;
  assign btn_left_o   = out_res.btn[ps2mt_pkg::HDR_LEFT];
  assign btn_right_o  = out_res.btn[ps2mt_pkg::HDR_RIGHT];
  assign btn_middle_o = out_res.btn[ps2mt_pkg::HDR_MIDDLE];

endmodule

>>> design/ps2mt_out_buf.sv
// Two-entry result buffer that decouples result production from the downstream stall.
`timescale 1ns / 1ps
module ps2mt_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ps2mt_pkg::result_t push_data_i,
  output logic               full_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ps2mt_pkg::result_t out_data_o
);

  logic               main_valid_q, main_valid_d;
  logic               skid_valid_q, skid_valid_d;
  ps2mt_pkg::result_t main_q, main_d;
  ps2mt_pkg::result_t skid_q, skid_d;
  logic               pop;

  assign pop = main_valid_q & ~out_stall_i;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (!main_valid_q || pop) begin
      // Refill the head from the skid entry first to keep order.
      if (skid_valid_q) begin
        main_d       = skid_q;
        main_valid_d = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        main_d       = push_data_i;
        main_valid_d = push_i;
      end
    end else if (push_i) begin
      // Head is held: park the new result.
      skid_d       = push_data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

endmodule

>>> design/ps2mouse_packet_tracker_dummy_guard.sv
// Byte framing and position update stage of the PS/2 packet tracker.
`timescale 1ns / 1ps
module ps2mt_frame (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         data_byte_i,
  output ps2mt_pkg::result_t result_o
);

  logic [ps2mt_pkg::COUNT_W-1:0]       count_q, count_d;
  logic                                resync_q, resync_d;
  logic [7:0]                          store_q [ps2mt_pkg::STORE_DEPTH];
  logic [7:0]                          store_d [ps2mt_pkg::STORE_DEPTH];
  logic [7:0]                          view    [ps2mt_pkg::STORE_DEPTH];
  logic signed [ps2mt_pkg::POS_W-1:0]  pos_x_q, pos_x_d;
  logic signed [ps2mt_pkg::POS_W-1:0]  pos_y_q, pos_y_d;
  logic [2:0]                          btn_q, btn_d;
  logic [ps2mt_pkg::COUNT_W:0]         next_cnt;
  logic                                last_byte;
  logic [7:0]                          head;
  logic signed [ps2mt_pkg::POS_W-1:0]  dx, dy;
  ps2mt_pkg::status_e                  status;

  always_comb begin
    // Packet bytes as they stand after this byte lands in the store.
    for (int i = 0; i < ps2mt_pkg::STORE_DEPTH; i++) begin
      view[i] = (count_q == ps2mt_pkg::COUNT_W'(i)) ? data_byte_i : store_q[i];
    end
  end

  assign next_cnt  = {1'b0, count_q} + (ps2mt_pkg::COUNT_W+1)'(1);
  assign last_byte = next_cnt >= (ps2mt_pkg::COUNT_W+1)'(ps2mt_pkg::PACKET_BYTES);
  assign head      = view[0];
  assign dx = {{(ps2mt_pkg::POS_W-9){head[ps2mt_pkg::HDR_XSIGN]}},
               head[ps2mt_pkg::HDR_XSIGN], view[1]};
  assign dy = {{(ps2mt_pkg::POS_W-9){head[ps2mt_pkg::HDR_YSIGN]}},
               head[ps2mt_pkg::HDR_YSIGN], view[2]};

  always_comb begin
    count_d  = count_q;
    resync_d = resync_q;
    store_d  = store_q;
    pos_x_d  = pos_x_q;
    pos_y_d  = pos_y_q;
    btn_d    = btn_q;
    status   = ps2mt_pkg::STATUS_ABSORBED;
    if (resync_q) begin
      store_d[0] = data_byte_i;
      if (data_byte_i[3:0] == ps2mt_pkg::RESYNC_NIBBLE) begin
        count_d  = ps2mt_pkg::COUNT_W'(1);
        resync_d = 1'b0;
        status   = ps2mt_pkg::STATUS_RESYNCED;
      end else begin
        count_d  = '0;
        status   = ps2mt_pkg::STATUS_REJECTED;
      end
    end else begin
      store_d = view;
      if (last_byte) begin
        count_d = '0;
        if (!head[ps2mt_pkg::HDR_SYNC]) begin
          resync_d = 1'b1;
          status   = ps2mt_pkg::STATUS_CORRUPT;
        end else begin
          pos_x_d = pos_x_q + dx;
          pos_y_d = pos_y_q - dy;
          btn_d   = head[2:0];
          status  = ps2mt_pkg::STATUS_APPLIED;
        end
      end else begin
        count_d = next_cnt[ps2mt_pkg::COUNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      resync_q <= 1'b0;
      pos_x_q  <= '0;
      pos_y_q  <= '0;
      btn_q    <= '0;
    end else if (accept_i) begin
      count_q  <= count_d;
      resync_q <= resync_d;
      pos_x_q  <= pos_x_d;
      pos_y_q  <= pos_y_d;
      btn_q    <= btn_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      store_q <= store_d;
    end
  end

  always_comb begin
    result_o.status = status;
    result_o.pos_x  = pos_x_d;
    result_o.pos_y  = pos_y_d;
    result_o.btn    = btn_d;
  end

endmodule

>>> design/ps2mt_checker.sv
// Port-level checker for the PS/2 packet tracker, bound to the top level.
`timescale 1ns / 1ps
module ps2mt_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [2:0]                         status_o,
  input logic signed [ps2mt_pkg::POS_W-1:0] pos_x_o,
  input logic signed [ps2mt_pkg::POS_W-1:0] pos_y_o,
  input logic                               btn_left_o,
  input logic                               btn_right_o,
  input logic                               btn_middle_o
);

  logic                               out_xfer;
  logic [2:0]                         last_status_q;
  logic signed [ps2mt_pkg::POS_W-1:0] last_x_q, last_y_q;
  logic [2:0]                         last_btn_q;

  assign out_xfer = out_valid_o & ~out_stall_i;

  // Hold what the last output transfer showed; reset matches the block reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_status_q <= ps2mt_pkg::STATUS_ABSORBED;
      last_x_q      <= '0;
      last_y_q      <= '0;
      last_btn_q    <= '0;
    end else if (out_xfer) begin
      last_status_q <= status_o;
      last_x_q      <= pos_x_o;
      last_y_q      <= pos_y_o;
      last_btn_q    <= {btn_middle_o, btn_right_o, btn_left_o};
    end
  end

  // Positions move only on an applied packet.
  a_pos_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && (status_o != ps2mt_pkg::STATUS_APPLIED)
    |-> (pos_x_o == last_x_q) && (pos_y_o == last_y_q))
    else $error("position changed without an applied packet");

  // Buttons change only on an applied packet.
  a_btn_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && (status_o != ps2mt_pkg::STATUS_APPLIED)
    |-> ({btn_middle_o, btn_right_o, btn_left_o} == last_btn_q))
    else $error("buttons changed without an applied packet");

  // While resyncing, each result is either a reject or the resync itself.
  a_resync_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && ((last_status_q == ps2mt_pkg::STATUS_CORRUPT) ||
                 (last_status_q == ps2mt_pkg::STATUS_REJECTED))
    |-> (status_o == ps2mt_pkg::STATUS_REJECTED) ||
        (status_o == ps2mt_pkg::STATUS_RESYNCED))
    else $error("left resync without a resync byte");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i
    |=> out_valid_o && $stable(status_o) && $stable(pos_x_o) && $stable(pos_y_o))
    else $error("stalled result changed");

endmodule

bind ps2_mouse_packet_tracker ps2mt_checker u_ps2mt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .pos_x_o      (pos_x_o),
  .pos_y_o      (pos_y_o),
  .btn_left_o   (btn_left_o),
  .btn_right_o  (btn_right_o),
  .btn_middle_o (btn_middle_o)
);

>>> bench/tb_top.sv
// Testbench for the PS/2 mouse packet tracker: byte stimulus, in-bench prediction, result check.
`timescale 1ns / 1ps
// Bytes go in one transfer at a time. At each accepted transfer the bench
// advances its own copy of the packet framing, the resync state, the two
// positions and the buttons, and queues the report it expects back. Every
// result transfer is compared field by field with the oldest queued report.
// Phases: a short directed sweep (sign extremes, all buttons, a corrupt
// packet, rejected and accepted resync bytes), a hold-off phase that fills
// the result buffer and forces the input stall, and a long random stream
// that is mostly well-formed packets, shaped by the bench's view of the
// framing state, with corrupt headers and noise mixed in.
module tb_top;

  localparam int WATCHDOG_CYCLES = 4000;
  localparam int HOLD_OFF_CYCLES = 60;

  logic                               clk_i        = 1'b0;
  logic                               rst_ni       = 1'b0;
  logic                               in_valid_i   = 1'b0;
  logic                               in_stall_o;
  logic [7:0]                         data_byte_i  = 8'h00;
  logic                               out_valid_o;
  logic                               out_stall_i  = 1'b0;
  logic [2:0]                         status_o;
  logic signed [ps2mt_pkg::POS_W-1:0] pos_x_o;
  logic signed [ps2mt_pkg::POS_W-1:0] pos_y_o;
  logic                               btn_left_o;
  logic                               btn_right_o;
  logic                               btn_middle_o;

  ps2_mouse_packet_tracker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .pos_x_o     (pos_x_o),
    .pos_y_o     (pos_y_o),
    .btn_left_o  (btn_left_o),
    .btn_right_o (btn_right_o),
    .btn_middle_o(btn_middle_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Bench copy of the tracker state.
  int                                 frame_pos;  // bytes of the current packet seen so far
  logic [7:0]                         hdr_byte;
  logic [7:0]                         x_low;
  logic [7:0]                         y_low;
  bit                                 resyncing;
  logic signed [ps2mt_pkg::POS_W-1:0] track_x;
  logic signed [ps2mt_pkg::POS_W-1:0] track_y;
  logic [2:0]                         track_btn;

  ps2mt_pkg::result_t pending_reports[$];
  int                 mismatch_cnt = 0;

  // Sender pacing and receiver pressure controls.
  bit gaps_on     = 1'b0;
  int burst_left  = 0;
  int hold_off_seq = 0;

  // Advance the tracker by one byte and return the report it owes for it.
  function automatic ps2mt_pkg::result_t track_byte(logic [7:0] b);
    ps2mt_pkg::result_t r;
    if (resyncing) begin
      // Only sync+right+left with middle clear restarts framing.
      hdr_byte  = b;
      frame_pos = 0;
      if (b[3:0] != ps2mt_pkg::RESYNC_NIBBLE) begin
        r.status = ps2mt_pkg::STATUS_REJECTED;
      end else begin
        frame_pos = 1;
        resyncing = 1'b0;
        r.status  = ps2mt_pkg::STATUS_RESYNCED;
      end
    end else begin
      case (frame_pos)
        0: hdr_byte = b;
        1: x_low    = b;
        2: y_low    = b;
        default: ;  // wheel byte, drop it
      endcase
      if (frame_pos + 1 >= ps2mt_pkg::PACKET_BYTES) begin
        frame_pos = 0;
        if (!hdr_byte[ps2mt_pkg::HDR_SYNC]) begin
          resyncing = 1'b1;
          r.status  = ps2mt_pkg::STATUS_CORRUPT;
        end else begin
          // 9-bit deltas: X adds, Y subtracts (screen down is positive).
          track_x   = track_x + {{(ps2mt_pkg::POS_W-9){hdr_byte[ps2mt_pkg::HDR_XSIGN]}},
                                 hdr_byte[ps2mt_pkg::HDR_XSIGN], x_low};
          track_y   = track_y - {{(ps2mt_pkg::POS_W-9){hdr_byte[ps2mt_pkg::HDR_YSIGN]}},
                                 hdr_byte[ps2mt_pkg::HDR_YSIGN], y_low};
          track_btn = hdr_byte[2:0];
          r.status  = ps2mt_pkg::STATUS_APPLIED;
        end
      end else begin
        frame_pos = frame_pos + 1;
        r.status  = ps2mt_pkg::STATUS_ABSORBED;
      end
    end
    r.pos_x = track_x;
    r.pos_y = track_y;
    r.btn   = track_btn;
    return r;
  endfunction

  // Offer one byte, hold it until the transfer, then record the expected report.
  // Call at a rising edge; returns at the edge of the transfer.
  task automatic push_byte(input logic [7:0] b);
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    pending_reports.push_back(track_byte(b));
  endtask

  // Insert a random gap between bursts when gaps are enabled.
  task automatic pace_sender();
    if (!gaps_on) return;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
      burst_left = $urandom_range(1, 16);
    end else begin
      burst_left--;
    end
  endtask

  // Receiver: switch among four random stall patterns; honor hold-off requests.
  always @(posedge clk_i) begin : receiver_stall
    int cyc;
    int mode;
    int hold_left;
    int seen_seq;
    if (cyc % 97 == 0) mode = $urandom_range(0, 3);
    cyc = cyc + 1;
    if (hold_off_seq != seen_seq) begin
      seen_seq  = hold_off_seq;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left   = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      case (mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 99) < 25);
        2: out_stall_i <= ($urandom_range(0, 99) < 60);
        default: out_stall_i <= (cyc % 5 < 2);
      endcase
    end
  end

  // Compare each result transfer with the oldest expected report.
  always @(posedge clk_i) begin : report_check
    ps2mt_pkg::result_t exp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: status %0d x %0d y %0d", status_o, pos_x_o, pos_y_o);
      end else begin
        exp = pending_reports.pop_front();
        if (status_o !== exp.status || pos_x_o !== exp.pos_x || pos_y_o !== exp.pos_y ||
            {btn_middle_o, btn_right_o, btn_left_o} !== exp.btn) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: status %0d/%0d x %0d/%0d y %0d/%0d btn %b/%b (exp/got)",
                     exp.status, status_o, exp.pos_x, pos_x_o, exp.pos_y, pos_y_o,
                     exp.btn, {btn_middle_o, btn_right_o, btn_left_o});
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk_i) begin : watchdog
    int idle;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle = 0;
    else idle = idle + 1;
    if (idle >= WATCHDOG_CYCLES) begin
      $display("FAIL ps2_mouse_packet_tracker");
      $finish;
    end
  end

  // Sign extremes, all buttons, corrupt packet, rejected and accepted resync bytes.
  task automatic test_directed_packets();
    logic [7:0] seq[$];
    seq = '{8'h0F, 8'hFF, 8'hFF, 8'h00,   // +255 / -255, all buttons
            8'hF8, 8'h00, 8'h00, 8'hFF,   // -256 / +256, overflow bits set
            8'h17, 8'h55, 8'hAA, 8'h12,   // sync clear: corrupt, enter resync
            8'h0F, 8'h03, 8'hF4, 8'h0A,   // each fails the resync nibble
            8'hFB, 8'h01, 8'h80, 8'h33};  // resync, then rest of the packet
    gaps_on = 1'b0;
    foreach (seq[i]) push_byte(seq[i]);
  endtask

  // Hold the receiver off while bytes keep coming, so the input stalls.
  task automatic test_output_hold_off();
    gaps_on = 1'b0;
    hold_off_seq++;
    repeat (40) push_byte(8'($urandom) | 8'h08);
  endtask

  // Mostly well-formed packets with random content; corrupt headers and noise mixed in.
  task automatic test_random_stream(input int n_items);
    logic [7:0] b;
    int         pick;
    for (int n = 0; n < n_items; n++) begin
      if (n % 100 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      b    = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (resyncing) begin
        if (pick < 30) b[3:0] = ps2mt_pkg::RESYNC_NIBBLE;
      end else if (frame_pos == 0) begin
        if (pick < 85) b[ps2mt_pkg::HDR_SYNC] = 1'b1;
        else if (pick < 95) b[ps2mt_pkg::HDR_SYNC] = 1'b0;
      end
      push_byte(b);
      pace_sender();
    end
  endtask

  initial begin
    frame_pos = 0;
    hdr_byte  = '0;
    x_low     = '0;
    y_low     = '0;
    resyncing = 1'b0;
    track_x   = '0;
    track_y   = '0;
    track_btn = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_packets();
    test_output_hold_off();
    test_random_stream(1290);

    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("PASS ps2_mouse_packet_tracker");
    end else begin
      $display("FAIL ps2_mouse_packet_tracker");
    end
    $finish;
  end

endmodule
